// ===== rtl/grid_cell_bracket_search_assert.svh =====
// assertion macros shared by the bracket search checkers
// expects clk and arst_n in the scope where a macro is used
`ifndef GRID_CELL_BRACKET_SEARCH_ASSERT_SVH
`define GRID_CELL_BRACKET_SEARCH_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define GCBS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bracket search check failed");

// consequent must hold in the cycle after the antecedent
`define GCBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bracket search check failed");

`endif

// ===== rtl/gcbs_pkg.sv =====
// shared types and constants of the two-axis bracket search
// no dependencies
`timescale 1ns / 1ps

package gcbs_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0]  CFG_TEMP_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0]  CFG_DENS_COUNT  = 1'd1;
	localparam logic [CFG_DATA_W-1:0] CFG_COUNT_RESET = 9'd256;

	// field widths of a beat
	localparam int KIND_W      = 2;
	localparam int ENTRY_IDX_W = 8;
	localparam int KEY_W       = 32;
	localparam int OUT_IDX_W   = 8;
	localparam int OUT_VAL_W   = 32;
	localparam int CORNER_W    = 16;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD_TEMP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_DENS = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH    = 2'd2;

	// control handed from one search cell to the next
	typedef struct packed {
		logic vld;
		logic pend;
	} gcbs_step_t;

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [ENTRY_IDX_W-1:0] entry_index;
		logic [KEY_W-1:0]       entry_value;
		logic [KEY_W-1:0]       temp_key;
		logic [KEY_W-1:0]       dens_key;
	} gcbs_item_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] temp_lower_index;
		logic [OUT_IDX_W-1:0] temp_upper_index;
		logic [OUT_IDX_W-1:0] dens_lower_index;
		logic [OUT_IDX_W-1:0] dens_upper_index;
		logic [OUT_VAL_W-1:0] temp_lower_value;
		logic [OUT_VAL_W-1:0] temp_upper_value;
		logic [OUT_VAL_W-1:0] dens_lower_value;
		logic [OUT_VAL_W-1:0] dens_upper_value;
		logic [CORNER_W-1:0]  corner_low_low;
		logic [CORNER_W-1:0]  corner_low_high;
		logic [CORNER_W-1:0]  corner_high_low;
		logic [CORNER_W-1:0]  corner_high_high;
	} gcbs_result_t;

endpackage

// ===== rtl/gcbs_chan_if.sv =====
// valid/ready channel carrying one payload beat
// payload type is given by the instantiating level
`timescale 1ns / 1ps

interface gcbs_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/gcbs_axis_mem.sv =====
// axis table storage: one write port, two registered read ports
// no dependencies
`timescale 1ns / 1ps

module gcbs_axis_mem #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr_a,
	output logic [DATA_W-1:0] rd_data_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [DATA_W-1:0] rd_data_b
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_a_q;
	logic [DATA_W-1:0] rd_b_q;

	// write and registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_q[rd_addr_a];
		rd_b_q <= mem_q[rd_addr_b];
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// ===== rtl/gcbs_cell.sv =====
// one halving step of the lower-bound search
// depends on gcbs_pkg
`timescale 1ns / 1ps

module gcbs_cell #(
	parameter int CNT_W   = 9,
	parameter int ADDR_W  = 8,
	parameter int VALUE_W = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gcbs_pkg::gcbs_step_t   ctl_in,
	input  logic [CNT_W-1:0]       first_in,
	input  logic [CNT_W-1:0]       len_in,
	input  logic [VALUE_W-1:0]     key_in,
	input  logic [VALUE_W-1:0]     rd_data,
	output gcbs_pkg::gcbs_step_t   ctl_out,
	output logic [CNT_W-1:0]       first_out,
	output logic [CNT_W-1:0]       len_out,
	output logic [VALUE_W-1:0]     key_out,
	output logic [ADDR_W-1:0]      rd_addr,
	output logic                   rd_en
);
	import gcbs_pkg::*;

	gcbs_step_t         ctl_q;
	logic [CNT_W-1:0]   first_q;
	logic [CNT_W-1:0]   len_q;
	logic [VALUE_W-1:0] key_q;
	logic [CNT_W-1:0]   half;
	logic [CNT_W-1:0]   half_n;
	logic [CNT_W-1:0]   first_n;
	logic [CNT_W-1:0]   len_n;
	logic               below;
	logic               pend_n;

	// search state taken from the previous cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		first_q <= first_in;
		len_q   <= len_in;
		key_q   <= key_in;
	end

	// resolve the compare issued by the previous cell, then pick the next probe
	always_comb begin
		half  = len_q >> 1;
		below = ctl_q.pend && (rd_data < key_q);
		if (below) begin
			first_n = first_q + half + CNT_W'(1);
			len_n   = len_q - half - CNT_W'(1);
		end else if (ctl_q.pend) begin
			first_n = first_q;
			len_n   = half;
		end else begin
			first_n = first_q;
			len_n   = len_q;
		end
		half_n = len_n >> 1;
		pend_n = (len_n != '0);
	end

	assign rd_addr   = ADDR_W'(first_n + half_n);
	assign rd_en     = ctl_q.vld && pend_n;
	assign ctl_out   = '{vld: ctl_q.vld, pend: pend_n};
	assign first_out = first_n;
	assign len_out   = len_n;
	assign key_out   = key_q;

endmodule

// ===== rtl/gcbs_axis.sv =====
// search engine for one axis: table, row of search cells, bracket stage
// depends on gcbs_pkg, gcbs_cell, gcbs_axis_mem
`timescale 1ns / 1ps

module gcbs_axis #(
	parameter int AXIS_DEPTH  = 256,
	parameter int VALUE_WIDTH = 32,
	parameter int ADDR_W      = 8,
	parameter int CNT_W       = 9
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [CNT_W-1:0]       count,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic                   wr_en,
	input  logic [ADDR_W-1:0]      wr_addr,
	input  logic [VALUE_WIDTH-1:0] wr_data,
	output logic                   done,
	output logic [ADDR_W-1:0]      lo_idx,
	output logic [ADDR_W-1:0]      hi_idx,
	output logic [VALUE_WIDTH-1:0] lo_val,
	output logic [VALUE_WIDTH-1:0] hi_val
);
	import gcbs_pkg::*;

	// one cell per halving step plus one that resolves the last compare
	localparam int STEPS = CNT_W + 1;

	gcbs_step_t             ctl_w   [STEPS+1];
	logic [CNT_W-1:0]       first_w [STEPS+1];
	logic [CNT_W-1:0]       len_w   [STEPS+1];
	logic [VALUE_WIDTH-1:0] key_w   [STEPS+1];
	logic [ADDR_W-1:0]      addr_w  [STEPS];
	logic                   rden_w  [STEPS];
	logic [ADDR_W-1:0]      addr_a;
	logic [VALUE_WIDTH-1:0] rd_data_a;
	logic [VALUE_WIDTH-1:0] rd_data_b;
	logic [CNT_W-1:0]       fin;
	logic                   fin_vld;
	logic [ADDR_W-1:0]      lo;
	logic [ADDR_W-1:0]      hi;
	logic                   done_s1;
	logic [ADDR_W-1:0]      lo_s1;
	logic [ADDR_W-1:0]      hi_s1;

	// head of the row: whole range, nothing pending
	assign ctl_w[0]   = '{vld: start, pend: 1'b0};
	assign first_w[0] = '0;
	assign len_w[0]   = count;
	assign key_w[0]   = key;

	for (genvar k = 0; k < STEPS; k++) begin : g_cell
		gcbs_cell #(
			.CNT_W   (CNT_W),
			.ADDR_W  (ADDR_W),
			.VALUE_W (VALUE_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl_in    (ctl_w[k]),
			.first_in  (first_w[k]),
			.len_in    (len_w[k]),
			.key_in    (key_w[k]),
			.rd_data   (rd_data_a),
			.ctl_out   (ctl_w[k+1]),
			.first_out (first_w[k+1]),
			.len_out   (len_w[k+1]),
			.key_out   (key_w[k+1]),
			.rd_addr   (addr_w[k]),
			.rd_en     (rden_w[k])
		);
	end

	// bracket from the final lower-bound position
	assign fin     = first_w[STEPS];
	assign fin_vld = ctl_w[STEPS].vld;

	always_comb begin
		if (fin == count) begin
			lo = ADDR_W'(count - CNT_W'(1));
			hi = ADDR_W'(count - CNT_W'(1));
		end else if (fin == '0) begin
			lo = '0;
			hi = ADDR_W'(1);
		end else begin
			lo = ADDR_W'(fin - CNT_W'(1));
			hi = ADDR_W'(fin);
		end
	end

	// port a serves the single active cell, then the lower bracket
	always_comb begin
		addr_a = '0;
		for (int k = 0; k < STEPS; k++) begin
			if (rden_w[k]) begin
				addr_a = addr_a | addr_w[k];
			end
		end
		if (fin_vld) begin
			addr_a = addr_a | lo;
		end
	end

	gcbs_axis_mem #(
		.DEPTH  (AXIS_DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (VALUE_WIDTH)
	) u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (addr_a),
		.rd_data_a (rd_data_a),
		.rd_addr_b (hi),
		.rd_data_b (rd_data_b)
	);

	// bracket indices line up with the table read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= fin_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_vld) begin
			lo_s1 <= lo;
			hi_s1 <= hi;
		end
	end

	assign done   = done_s1;
	assign lo_idx = lo_s1;
	assign hi_idx = hi_s1;
	assign lo_val = rd_data_a;
	assign hi_val = rd_data_b;

endmodule

// ===== rtl/grid_cell_bracket_search.sv =====
// Two-axis bracket search: temperature and density tables with lower-bound lookup.
// Channels: item (sink) takes load and search beats, result (source) gives one
// beat per search; both are valid/ready, a beat moves when valid and ready are high.
// Load beats write one table entry; they give no result.
// Configuration: cfg_wr_en with cfg_index 0 (temperature count) or 1 (density
// count); write only while no search is in flight.
// A search runs through a row of clog2(AXIS_DEPTH+1)+1 cells per axis, one table
// probe per cell per cycle, both axes side by side, then a bracket read, a corner
// multiply and the output register.
// One search is in flight at a time: a new search beat is taken only once the
// last result has entered the output register.
// Reset clears the control and sets both counts to 256; table contents stay
// undefined until loaded.
// When the receiver stalls the result holds in the output register; item ready
// rises once a result has entered it, and a later search waits in the corner
// stage, keeping item ready low, until the output register frees up.
// Depends on gcbs_pkg, gcbs_chan_if, gcbs_axis.
`timescale 1ns / 1ps

module grid_cell_bracket_search #(
	parameter int AXIS_DEPTH  = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [gcbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gcbs_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
	gcbs_chan_if.sink                         item,
	gcbs_chan_if.source                       result
);
	import gcbs_pkg::*;

	localparam int ADDR_W    = $clog2(AXIS_DEPTH);
	localparam int CNT_W     = $clog2(AXIS_DEPTH + 1);
	localparam int WIDE_W    = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
	localparam int IDX_CMP_W = (CNT_W > ENTRY_IDX_W) ? CNT_W : ENTRY_IDX_W;
	localparam int PROD_W    = ADDR_W + CNT_W;

	logic [CFG_DATA_W-1:0]  tcount_q;
	logic [CFG_DATA_W-1:0]  dcount_q;
	logic [CNT_W-1:0]       t_cnt;
	logic [CNT_W-1:0]       d_cnt;
	logic                   busy_q;
	logic                   item_fire;
	logic                   search_fire;
	logic                   idx_ok;
	logic                   t_wr_en;
	logic                   d_wr_en;
	logic [ADDR_W-1:0]      wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic [VALUE_WIDTH-1:0] t_key;
	logic [VALUE_WIDTH-1:0] d_key;
	logic                   t_done;
	logic                   d_done;
	logic [ADDR_W-1:0]      t_lo;
	logic [ADDR_W-1:0]      t_hi;
	logic [ADDR_W-1:0]      d_lo;
	logic [ADDR_W-1:0]      d_hi;
	logic [VALUE_WIDTH-1:0] t_lo_val;
	logic [VALUE_WIDTH-1:0] t_hi_val;
	logic [VALUE_WIDTH-1:0] d_lo_val;
	logic [VALUE_WIDTH-1:0] d_hi_val;
	logic                   s1_vld;
	logic                   vld_s2;
	logic [ADDR_W-1:0]      tlo_s2;
	logic [ADDR_W-1:0]      thi_s2;
	logic [ADDR_W-1:0]      dlo_s2;
	logic [ADDR_W-1:0]      dhi_s2;
	logic [VALUE_WIDTH-1:0] tlo_val_s2;
	logic [VALUE_WIDTH-1:0] thi_val_s2;
	logic [VALUE_WIDTH-1:0] dlo_val_s2;
	logic [VALUE_WIDTH-1:0] dhi_val_s2;
	logic [PROD_W-1:0]      plo_s2;
	logic [PROD_W-1:0]      phi_s2;
	logic                   s2_move;
	logic                   out_vld_q;
	gcbs_result_t           out_q;

	// clamp a count register into the usable range of the table
	function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_DATA_W-1:0] c);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(c);
		if (w < WIDE_W'(2)) begin
			return CNT_W'(2);
		end else if (w > WIDE_W'(AXIS_DEPTH)) begin
			return CNT_W'(AXIS_DEPTH);
		end else begin
			return CNT_W'(w);
		end
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcount_q <= CFG_COUNT_RESET;
			dcount_q <= CFG_COUNT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_TEMP_COUNT: tcount_q <= cfg_wr_data;
				CFG_DENS_COUNT: dcount_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	assign t_cnt = eff_count(tcount_q);
	assign d_cnt = eff_count(dcount_q);

	// input beat decode
	assign item.ready  = !busy_q;
	assign item_fire   = item.valid && !busy_q;
	assign search_fire = item_fire && (item.payload.kind == KIND_SEARCH);
	assign idx_ok      = IDX_CMP_W'(item.payload.entry_index) < IDX_CMP_W'(AXIS_DEPTH);
	assign t_wr_en     = item_fire && idx_ok && (item.payload.kind == KIND_LOAD_TEMP);
	assign d_wr_en     = item_fire && idx_ok && (item.payload.kind == KIND_LOAD_DENS);
	assign wr_addr     = ADDR_W'(item.payload.entry_index);
	assign wr_data     = VALUE_WIDTH'(item.payload.entry_value);
	assign t_key       = VALUE_WIDTH'(item.payload.temp_key);
	assign d_key       = VALUE_WIDTH'(item.payload.dens_key);

	gcbs_axis #(
		.AXIS_DEPTH  (AXIS_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH),
		.ADDR_W      (ADDR_W),
		.CNT_W       (CNT_W)
	) u_temp_axis (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (search_fire),
		.count   (t_cnt),
		.key     (t_key),
		.wr_en   (t_wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.done    (t_done),
		.lo_idx  (t_lo),
		.hi_idx  (t_hi),
		.lo_val  (t_lo_val),
		.hi_val  (t_hi_val)
	);

	gcbs_axis #(
		.AXIS_DEPTH  (AXIS_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH),
		.ADDR_W      (ADDR_W),
		.CNT_W       (CNT_W)
	) u_dens_axis (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (search_fire),
		.count   (d_cnt),
		.key     (d_key),
		.wr_en   (d_wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.done    (d_done),
		.lo_idx  (d_lo),
		.hi_idx  (d_hi),
		.lo_val  (d_lo_val),
		.hi_val  (d_hi_val)
	);

	// both axes finish in the same cycle
	assign s1_vld  = t_done && d_done;
	assign s2_move = vld_s2 && (!out_vld_q || result.ready);

	// control: busy flag, corner stage and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (search_fire) begin
				busy_q <= 1'b1;
			end else if (s2_move) begin
				busy_q <= 1'b0;
			end
			if (s1_vld) begin
				vld_s2 <= 1'b1;
			end else if (s2_move) begin
				vld_s2 <= 1'b0;
			end
			if (s2_move) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// bracket stage: indices, values and the row offsets of the two density brackets
	always_ff @(posedge clk) begin
		if (s1_vld) begin
			tlo_s2     <= t_lo;
			thi_s2     <= t_hi;
			dlo_s2     <= d_lo;
			dhi_s2     <= d_hi;
			tlo_val_s2 <= t_lo_val;
			thi_val_s2 <= t_hi_val;
			dlo_val_s2 <= d_lo_val;
			dhi_val_s2 <= d_hi_val;
			plo_s2     <= PROD_W'(d_lo) * PROD_W'(t_cnt);
			phi_s2     <= PROD_W'(d_hi) * PROD_W'(t_cnt);
		end
	end

	// output register with the corner additions
	always_ff @(posedge clk) begin
		if (s2_move) begin
			out_q.temp_lower_index <= OUT_IDX_W'(tlo_s2);
			out_q.temp_upper_index <= OUT_IDX_W'(thi_s2);
			out_q.dens_lower_index <= OUT_IDX_W'(dlo_s2);
			out_q.dens_upper_index <= OUT_IDX_W'(dhi_s2);
			out_q.temp_lower_value <= OUT_VAL_W'(tlo_val_s2);
			out_q.temp_upper_value <= OUT_VAL_W'(thi_val_s2);
			out_q.dens_lower_value <= OUT_VAL_W'(dlo_val_s2);
			out_q.dens_upper_value <= OUT_VAL_W'(dhi_val_s2);
			out_q.corner_low_low   <= CORNER_W'(plo_s2 + PROD_W'(tlo_s2));
			out_q.corner_low_high  <= CORNER_W'(plo_s2 + PROD_W'(thi_s2));
			out_q.corner_high_low  <= CORNER_W'(phi_s2 + PROD_W'(tlo_s2));
			out_q.corner_high_high <= CORNER_W'(phi_s2 + PROD_W'(thi_s2));
		end
	end

	assign result.valid   = out_vld_q;
	assign result.payload = out_q;

endmodule

// ===== rtl/gcbs_checker.sv =====
// port-level checks on the bracket search, bound to the top level
// depends on gcbs_pkg and grid_cell_bracket_search_assert.svh
`timescale 1ns / 1ps
`include "grid_cell_bracket_search_assert.svh"

module gcbs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_valid,
	input logic                               item_ready,
	input logic [gcbs_pkg::KIND_W-1:0]        item_kind,
	input logic                               result_valid,
	input logic                               result_ready,
	input gcbs_pkg::gcbs_result_t             result_payload
);
	import gcbs_pkg::*;

	logic                 result_wait;
	logic                 search_beat;
	logic [OUT_IDX_W-1:0] temp_gap;
	logic [OUT_IDX_W-1:0] dens_gap;
	logic [CORNER_W-1:0]  corner_gap;

	// handshake views and bracket widths seen on the result beat
	assign result_wait = result_valid && !result_ready;
	assign search_beat = item_valid && item_ready && (item_kind == KIND_SEARCH);
	assign temp_gap    = OUT_IDX_W'(result_payload.temp_upper_index
		- result_payload.temp_lower_index);
	assign dens_gap    = OUT_IDX_W'(result_payload.dens_upper_index
		- result_payload.dens_lower_index);
	assign corner_gap  = CORNER_W'(result_payload.corner_low_high
		- result_payload.corner_low_low);

	// a waiting result beat keeps its valid and contents
	`GCBS_ASSERT_NEXT(a_result_hold, result_wait, result_valid && $stable(result_payload))

	// a search beat closes the input until its result enters the output register
	`GCBS_ASSERT_NEXT(a_search_blocks, search_beat, !item_ready)

	// brackets are one entry apart, or collapsed above the top
	`GCBS_ASSERT_NOW(a_temp_bracket, result_valid, temp_gap <= OUT_IDX_W'(1))

	`GCBS_ASSERT_NOW(a_dens_bracket, result_valid, dens_gap <= OUT_IDX_W'(1))

	// corners of one row differ by the temperature bracket width
	`GCBS_ASSERT_NOW(a_corner_step, result_valid, corner_gap == CORNER_W'(temp_gap))

endmodule

bind grid_cell_bracket_search gcbs_checker u_gcbs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.item_kind      (item.payload.kind),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_payload (result.payload)
);

// ===== test/tb.sv =====
// testbench for grid_cell_bracket_search: loads both axis tables, runs bracket searches
// and checks every result beat against a directed expectation or an in-bench predictor of the lower-bound search
// depends on gcbs_pkg, gcbs_chan_if and the grid_cell_bracket_search rtl
`timescale 1ns / 1ps

module tb;
	import gcbs_pkg::*;

	localparam int AXIS_DEPTH    = 256;
	localparam int SETTLE_CYCLES = 16;
	localparam int STUCK_LIMIT   = 400;
	localparam int PHASES        = 5;
	localparam int BIG_PHASE     = 2;
	localparam int MAX_PRINTED   = 40;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		gcbs_item_t   beat;
		bit           typed;
		gcbs_result_t want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wr_data;

	gcbs_chan_if #(.payload_t(gcbs_item_t))   item_ch ();
	gcbs_chan_if #(.payload_t(gcbs_result_t)) result_ch ();

	grid_cell_bracket_search uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.item        (item_ch),
		.result      (result_ch)
	);

	// bench copy of the axis tables and count registers
	logic [OUT_VAL_W-1:0]  temp_table [AXIS_DEPTH];
	logic [OUT_VAL_W-1:0]  dens_table [AXIS_DEPTH];
	logic [CFG_DATA_W-1:0] temp_count_q;
	logic [CFG_DATA_W-1:0] dens_count_q;

	gcbs_result_t pending_brackets [$];
	stim_row_t    directed_rows [$];

	int mismatches       = 0;
	int searches_sent    = 0;
	int loads_sent       = 0;
	int brackets_checked = 0;
	int settings_written = 0;
	int stuck_cycles     = 0;
	bit idle_on          = 1'b1;

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int effective_count(input logic [CFG_DATA_W-1:0] c);
		if (c < 2) return 2;
		if (c > AXIS_DEPTH) return AXIS_DEPTH;
		return int'(c);
	endfunction

	// halving lower-bound search on one axis, then bracket clamp at both ends
	function automatic void axis_bracket(input bit on_dens, input logic [KEY_W-1:0] key,
		input int cnt, output int lo, output int hi);
		int first, len, half, mid;
		logic [OUT_VAL_W-1:0] probe;
		first = 0;
		len = cnt;
		while (len > 0) begin
			half = len / 2;
			mid = first + half;
			probe = on_dens ? dens_table[mid] : temp_table[mid];
			if (probe < key) begin
				first = mid + 1;
				len = len - half - 1;
			end else begin
				len = half;
			end
		end
		if (first == cnt) begin
			lo = cnt - 1;
			hi = cnt - 1;
		end else if (first == 0) begin
			lo = 0;
			hi = 1;
		end else begin
			lo = first - 1;
			hi = first;
		end
	endfunction

	function automatic gcbs_result_t predict_bracket(input gcbs_item_t b);
		int tc, dc, tl, th, dl, dh, ll, lh, hl, hh;
		gcbs_result_t r;
		tc = effective_count(temp_count_q);
		dc = effective_count(dens_count_q);
		axis_bracket(1'b0, b.temp_key, tc, tl, th);
		axis_bracket(1'b1, b.dens_key, dc, dl, dh);
		ll = dl * tc + tl;
		lh = dl * tc + th;
		hl = dh * tc + tl;
		hh = dh * tc + th;
		r.temp_lower_index = tl[OUT_IDX_W-1:0];
		r.temp_upper_index = th[OUT_IDX_W-1:0];
		r.dens_lower_index = dl[OUT_IDX_W-1:0];
		r.dens_upper_index = dh[OUT_IDX_W-1:0];
		r.temp_lower_value = temp_table[tl];
		r.temp_upper_value = temp_table[th];
		r.dens_lower_value = dens_table[dl];
		r.dens_upper_value = dens_table[dh];
		r.corner_low_low   = ll[CORNER_W-1:0];
		r.corner_low_high  = lh[CORNER_W-1:0];
		r.corner_high_low  = hl[CORNER_W-1:0];
		r.corner_high_high = hh[CORNER_W-1:0];
		return r;
	endfunction

	function automatic gcbs_item_t make_beat(input logic [KIND_W-1:0] kind,
		input logic [ENTRY_IDX_W-1:0] idx, input logic [KEY_W-1:0] val,
		input logic [KEY_W-1:0] tkey, input logic [KEY_W-1:0] dkey);
		gcbs_item_t b;
		b.kind = kind;
		b.entry_index = idx;
		b.entry_value = val;
		b.temp_key = tkey;
		b.dens_key = dkey;
		return b;
	endfunction

	// key near the table contents half of the time, at the ends or anywhere otherwise
	function automatic logic [KEY_W-1:0] pick_key(input bit on_dens, input int cnt);
		int r, k;
		logic [KEY_W-1:0] v;
		r = $urandom_range(0, 9);
		k = $urandom_range(0, cnt - 1);
		v = on_dens ? dens_table[k] : temp_table[k];
		case (r)
			0: return '0;
			1: return '1;
			2, 3, 4: return v;
			5: return v + 1;
			6: return v - 1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return CFG_DATA_W'($urandom_range(0, 1));
		if (r == 1) return 9'd2;
		if (r == 2) return CFG_DATA_W'($urandom_range(21, 64));
		return CFG_DATA_W'($urandom_range(3, 20));
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < MAX_PRINTED)
			$display("result beat %0d: %s got %h want %h", brackets_checked, what, got, want);
		mismatches++;
	endtask

	task automatic check_bracket(input gcbs_result_t got, input gcbs_result_t want);
		if (got.temp_lower_index !== want.temp_lower_index)
			note_mismatch("temp_lower_index", got.temp_lower_index, want.temp_lower_index);
		if (got.temp_upper_index !== want.temp_upper_index)
			note_mismatch("temp_upper_index", got.temp_upper_index, want.temp_upper_index);
		if (got.dens_lower_index !== want.dens_lower_index)
			note_mismatch("dens_lower_index", got.dens_lower_index, want.dens_lower_index);
		if (got.dens_upper_index !== want.dens_upper_index)
			note_mismatch("dens_upper_index", got.dens_upper_index, want.dens_upper_index);
		if (got.temp_lower_value !== want.temp_lower_value)
			note_mismatch("temp_lower_value", got.temp_lower_value, want.temp_lower_value);
		if (got.temp_upper_value !== want.temp_upper_value)
			note_mismatch("temp_upper_value", got.temp_upper_value, want.temp_upper_value);
		if (got.dens_lower_value !== want.dens_lower_value)
			note_mismatch("dens_lower_value", got.dens_lower_value, want.dens_lower_value);
		if (got.dens_upper_value !== want.dens_upper_value)
			note_mismatch("dens_upper_value", got.dens_upper_value, want.dens_upper_value);
		if (got.corner_low_low !== want.corner_low_low)
			note_mismatch("corner_low_low", got.corner_low_low, want.corner_low_low);
		if (got.corner_low_high !== want.corner_low_high)
			note_mismatch("corner_low_high", got.corner_low_high, want.corner_low_high);
		if (got.corner_high_low !== want.corner_high_low)
			note_mismatch("corner_high_low", got.corner_high_low, want.corner_high_low);
		if (got.corner_high_high !== want.corner_high_high)
			note_mismatch("corner_high_high", got.corner_high_high, want.corner_high_high);
	endtask

	// update the bench tables, or queue the bracket a search beat should give
	task automatic absorb_beat(input gcbs_item_t b, input bit typed, input gcbs_result_t want);
		case (b.kind)
			KIND_LOAD_TEMP: begin
				temp_table[b.entry_index] = b.entry_value;
				loads_sent++;
			end
			KIND_LOAD_DENS: begin
				dens_table[b.entry_index] = b.entry_value;
				loads_sent++;
			end
			KIND_SEARCH: begin
				pending_brackets.insert(pending_brackets.size(),
					typed ? want : predict_bracket(b));
				searches_sent++;
			end
			default: ;
		endcase
	endtask

	// one item beat, with an occasional random gap ahead of it while idle_on is set
	task automatic send_beat(input gcbs_item_t b, input bit typed, input gcbs_result_t want);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.payload <= b;
		do @(posedge clk); while (!item_ch.ready);
		absorb_beat(b, typed, want);
	endtask

	task automatic add_row(input gcbs_item_t b, input bit typed, input gcbs_result_t want);
		stim_row_t row;
		row.beat = b;
		row.typed = typed;
		row.want = want;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	// hold the sender off until every queued bracket has come back
	task automatic wait_for_brackets();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_brackets.size() != 0) @(posedge clk);
	endtask

	task automatic settle_block();
		wait_for_brackets();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both count registers, back to back, only while the block is idle
	task automatic set_counts(input logic [CFG_DATA_W-1:0] tc, input logic [CFG_DATA_W-1:0] dc);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_TEMP_COUNT;
		cfg_wr_data <= tc;
		@(negedge clk);
		cfg_index <= CFG_DENS_COUNT;
		cfg_wr_data <= dc;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		temp_count_q = tc;
		dens_count_q = dc;
		settings_written++;
	endtask

	// fill the valid part of both tables: ascending, crowded with equal entries, or unsorted
	task automatic load_tables(input int nt, input int nd);
		int mode, i;
		logic [KEY_W-1:0] tv, dv, t_step, d_step;
		mode = $urandom_range(0, 7);
		tv = $urandom_range(0, 32'h0FFF_FFFF);
		dv = $urandom_range(0, 32'h0FFF_FFFF);
		t_step = (32'hFFFF_FFFF - tv) / nt;
		d_step = (32'hFFFF_FFFF - dv) / nd;
		if (mode == 0) begin
			t_step = 2;
			d_step = 2;
		end
		for (i = 0; i < nt || i < nd; i++) begin
			if (i < nt) begin
				send_beat(make_beat(KIND_LOAD_TEMP, 8'(i), (mode == 1) ? $urandom() : tv,
					$urandom(), $urandom()), 1'b0, '0);
				tv = tv + $urandom_range(0, t_step);
			end
			if (i < nd) begin
				send_beat(make_beat(KIND_LOAD_DENS, 8'(i), (mode == 1) ? $urandom() : dv,
					$urandom(), $urandom()), 1'b0, '0);
				dv = dv + $urandom_range(0, d_step);
			end
		end
	endtask

	// one setting of the counts: reload tables, then searches with a little noise
	task automatic run_phase(input int p);
		logic [CFG_DATA_W-1:0] tc_w, dc_w;
		int nt, nd, n_search, searched, noise_span, r;
		bit paused;
		gcbs_item_t b;
		if (p == BIG_PHASE) begin
			tc_w = 9'd511;
			dc_w = pick_count();
		end else begin
			tc_w = pick_count();
			dc_w = pick_count();
		end
		idle_on = !(p == 3 || p >= PHASES - 2);
		settle_block();
		set_counts(tc_w, dc_w);
		nt = effective_count(tc_w);
		nd = effective_count(dc_w);
		load_tables(nt, nd);
		n_search = (p == BIG_PHASE) ? 40 : $urandom_range(20, 32);
		noise_span = (p == BIG_PHASE) ? 80 : 16;
		searched = 0;
		paused = 1'b0;
		while (searched < n_search) begin
			if (!paused && searched == n_search / 2) begin
				wait_for_brackets();
				paused = 1'b1;
			end
			r = $urandom_range(0, noise_span - 1);
			if (r == 0)
				b = make_beat(KIND_LOAD_TEMP, 8'($urandom()), $urandom(), $urandom(), $urandom());
			else if (r == 1)
				b = make_beat(KIND_LOAD_DENS, 8'($urandom()), $urandom(), $urandom(), $urandom());
			else if (r == 2)
				b = make_beat(KIND_UNUSED, 8'($urandom()), $urandom(), $urandom(), $urandom());
			else begin
				b = make_beat(KIND_SEARCH, 8'($urandom()), $urandom(),
					pick_key(1'b0, nt), pick_key(1'b1, nd));
				searched++;
			end
			send_beat(b, 1'b0, '0);
		end
	endtask

	// result receiver: ready drops in random bursts while idle_on is set
	initial begin
		int hold;
		hold = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(0, 3);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// result beats against the oldest queued bracket, and the stall count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (result_ch.valid && result_ch.ready) begin
				if (pending_brackets.size() == 0)
					note_mismatch("result beat with nothing queued", '0, '0);
				else
					check_bracket(result_ch.payload, pending_brackets.pop_front());
				brackets_checked++;
			end
		end
	end

	// watchdog
	initial begin
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int p;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wr_data = '0;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		for (p = 0; p < AXIS_DEPTH; p++) begin
			temp_table[p] = '0;
			dens_table[p] = '0;
		end
		temp_count_q = CFG_COUNT_RESET;
		dens_count_q = CFG_COUNT_RESET;

		// directed table: two-entry axes, both ends of every key and value
		add_row(make_beat(KIND_LOAD_TEMP, 8'd0, 32'd100, 32'hA5A5_A5A5, 32'h5A5A_5A5A), 1'b0, '0);
		add_row(make_beat(KIND_LOAD_TEMP, 8'd1, 32'hFFFF_FFFF, '0, '0), 1'b0, '0);
		add_row(make_beat(KIND_LOAD_DENS, 8'd0, 32'd0, '1, '1), 1'b0, '0);
		add_row(make_beat(KIND_LOAD_DENS, 8'd1, 32'd500, '0, '0), 1'b0, '0);
		add_row(make_beat(KIND_LOAD_TEMP, 8'd255, 32'h1234_5678, '0, '0), 1'b0, '0);
		add_row(make_beat(KIND_LOAD_DENS, 8'd255, 32'hFFFF_FFFF, '0, '0), 1'b0, '0);
		add_row(make_beat(KIND_UNUSED, 8'd255, '1, '1, '1), 1'b0, '0);
		// keys at the bottom: both axes bracket 0 and 1
		add_row(make_beat(KIND_SEARCH, 8'd0, '0, 32'd0, 32'd0), 1'b1,
			gcbs_result_t'{8'd0, 8'd1, 8'd0, 8'd1, 32'd100, 32'hFFFF_FFFF, 32'd0, 32'd500,
			16'd0, 16'd1, 16'd2, 16'd3});
		// keys at the top: density above its last entry clamps to 1 and 1
		add_row(make_beat(KIND_SEARCH, 8'hFF, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
			gcbs_result_t'{8'd0, 8'd1, 8'd1, 8'd1, 32'd100, 32'hFFFF_FFFF, 32'd500, 32'd500,
			16'd2, 16'd3, 16'd2, 16'd3});
		add_row(make_beat(KIND_SEARCH, 8'd0, '0, 32'd101, 32'd500), 1'b1,
			gcbs_result_t'{8'd0, 8'd1, 8'd0, 8'd1, 32'd100, 32'hFFFF_FFFF, 32'd0, 32'd500,
			16'd0, 16'd1, 16'd2, 16'd3});
		add_row(make_beat(KIND_SEARCH, 8'd0, '0, 32'd100, 32'd501), 1'b1,
			gcbs_result_t'{8'd0, 8'd1, 8'd1, 8'd1, 32'd100, 32'hFFFF_FFFF, 32'd500, 32'd500,
			16'd2, 16'd3, 16'd2, 16'd3});
		add_row(make_beat(KIND_SEARCH, 8'd7, 32'd3, 32'd99, 32'd1), 1'b0, '0);
		add_row(make_beat(KIND_LOAD_TEMP, 8'd1, 32'd100, '0, '0), 1'b0, '0);
		add_row(make_beat(KIND_SEARCH, 8'd0, '0, 32'd100, 32'd499), 1'b0, '0);
		add_row(make_beat(KIND_SEARCH, 8'd0, '0, 32'd101, 32'd0), 1'b0, '0);

		// reset
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// counts below range act as two
		set_counts(9'd0, 9'd1);
		foreach (directed_rows[p])
			send_beat(directed_rows[p].beat, directed_rows[p].typed, directed_rows[p].want);

		for (p = 0; p < PHASES; p++)
			run_phase(p);

		settle_block();
		$display("checked %0d result beats from %0d searches, %0d table loads, %0d count settings",
			brackets_checked, searches_sent, loads_sent, settings_written);
		$display("counts from 0 to 511, keys at both ends, on and beside entries, unsorted tables");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gcbs_pkg.sv
rtl/gcbs_chan_if.sv
rtl/gcbs_axis_mem.sv
rtl/gcbs_cell.sv
rtl/gcbs_axis.sv
rtl/grid_cell_bracket_search.sv
rtl/gcbs_checker.sv
test/tb.sv
